// ===== rtl/mrh_pkg.sv =====
// ----------------------------------------------------------------------------
// mrh_pkg
// Shared constants, command codes and control types of the ML-DSA rounding
// and hint unit (q = 8380417, d = 13).
// ----------------------------------------------------------------------------
package mrh_pkg;

  localparam int unsigned CoeffW  = 23;
  localparam int unsigned LowInW  = 24;
  localparam int unsigned HighW   = 10;
  localparam int unsigned LowW    = 19;
  localparam int unsigned P2rLowW = 14;
  localparam int unsigned DecHW   = 6;
  localparam int unsigned ProdW   = 30;

  localparam logic [CoeffW-1:0] Q     = 23'd8380417;
  localparam logic [CoeffW-1:0] HalfQ = 23'd4190208;

  localparam logic [18:0] Gamma2Small    = 19'd95232;
  localparam logic [18:0] Gamma2Large    = 19'd261888;
  localparam logic [19:0] TwoGamma2Small = 20'd190464;
  localparam logic [19:0] TwoGamma2Large = 20'd523776;

  localparam logic [13:0] MulSmall = 14'd11275;
  localparam logic [13:0] MulLarge = 14'd1025;

  localparam logic [DecHW-1:0] HighMaxSmall = 6'd43;
  localparam logic [DecHW-1:0] HighMaskLarge = 6'd15;

  typedef enum logic [1:0] {
    CMD_POWER2ROUND = 2'd0,
    CMD_DECOMPOSE   = 2'd1,
    CMD_MAKE_HINT   = 2'd2,
    CMD_USE_HINT    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } dec_en_t;

endpackage

// ===== rtl/mrh_if.sv =====
// ----------------------------------------------------------------------------
// mrh_if
// Valid/ready channels of the rounding and hint unit: the item channel and
// the result channel.
// ----------------------------------------------------------------------------
interface mrh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [22:0] coeff;
  logic [23:0] low_in;
  logic [9:0]  high_in;
  logic        hint_in;

  modport source (output valid, output command, output coeff, output low_in,
                  output high_in, output hint_in, input ready);
  modport sink   (input valid, input command, input coeff, input low_in,
                  input high_in, input hint_in, output ready);
endinterface

interface mrh_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  high_part;
  logic [18:0] low_part;
  logic        hint_bit;

  modport source (output valid, output high_part, output low_part,
                  output hint_bit, input ready);
  modport sink   (input valid, input high_part, input low_part,
                  input hint_bit, output ready);
endinterface

// ===== rtl/mrh_decompose.sv =====
// ----------------------------------------------------------------------------
// mrh_decompose
// Three-stage high-part datapath of Decompose: reciprocal multiply, rounding
// and range fold, then the multiple of 2*gamma2 to subtract.
// ----------------------------------------------------------------------------
module mrh_decompose (
  input  logic              clk_i,
  input  mrh_pkg::dec_en_t  en_i,
  input  logic [22:0]       a_i,
  input  logic              gsel_i,
  output logic [5:0]        high_o,
  output logic [22:0]       mult_o
);
  import mrh_pkg::*;

  logic [CoeffW-1:0] a_rnd;
  logic [15:0]       h0;
  logic [ProdW-1:0]  prod_d, prod_q;
  logic              gsel2_q, gsel3_q;

  logic [ProdW:0]    sum_large, sum_small;
  logic [6:0]        h_small;
  logic [DecHW-1:0]  h3_d, h3_q;

  logic [DecHW-1:0]  h4_q;
  logic [CoeffW-1:0] m_d, m_q;

  // stage 2: ceil(a / 128) times the reciprocal constant
  always_comb begin
    a_rnd  = a_i + 23'd127;
    h0     = a_rnd[22:7];
    prod_d = gsel_i ? (ProdW'(h0) * ProdW'(MulLarge)) : (ProdW'(h0) * ProdW'(MulSmall));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q  <= prod_d;
      gsel2_q <= gsel_i;
    end
  end

  // stage 3: round and fold into the high-part range
  always_comb begin
    sum_large = {1'b0, prod_q} + 31'(1 << 21);
    sum_small = {1'b0, prod_q} + 31'(1 << 23);
    h_small   = sum_small[30:24];
    if (gsel2_q) begin
      h3_d = {2'b00, sum_large[25:22]} & HighMaskLarge;
    end else if (h_small > 7'(HighMaxSmall)) begin
      h3_d = '0;
    end else begin
      h3_d = h_small[DecHW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      h3_q    <= h3_d;
      gsel3_q <= gsel2_q;
    end
  end

  // stage 4: h * 2 * gamma2
  always_comb begin
    m_d = gsel3_q ? CoeffW'(26'(h3_q) * 26'(TwoGamma2Large))
                  : CoeffW'(26'(h3_q) * 26'(TwoGamma2Small));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      h4_q <= h3_q;
      m_q  <= m_d;
    end
  end

  assign high_o = h4_q;
  assign mult_o = m_q;

endmodule

// ===== rtl/mldsa_rounding_hint_unit.sv =====
// ----------------------------------------------------------------------------
// mldsa_rounding_hint_unit
// ML-DSA coefficient rounding: Power2Round, Decompose, MakeHint and UseHint
// over q = 8380417, five-stage pipeline with per-stage valid bits.
//
//   port          dir   kind        transfer
//   in_if         in    valid/ready one coefficient item with command
//   out_if        out   valid/ready one result per item
//   cfg_we_i/..   in    write only  gamma2_select, taken when cfg_we_i is high
//
// One item per cycle sustained while the output is not stalled.
// The depth is set by the Decompose path: reduce, multiply, round, multiply
// by 2*gamma2, then subtract with wrap and hint step.
// Reset clears the valid bits and gamma2_select.
// A stall holds only the stages that are full; bubbles still close up.
// ----------------------------------------------------------------------------
module mldsa_rounding_hint_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  mrh_in_if.sink     in_if,
  mrh_out_if.source  out_if
);
  import mrh_pkg::*;

  logic gamma2_select_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  dec_en_t dec_en;

  // stage 1
  cmd_e                     cmd1_q;
  logic [CoeffW-1:0]        a1_d, a1_q;
  logic [LowInW-1:0]        lin1_q;
  logic                     hnz1_q, hint1_q, gsel1_q;

  // stage 2
  cmd_e                     cmd2_q;
  logic [CoeffW-1:0]        a2_q;
  logic                     hint2_q, gsel2_q, mh2_d, mh2_q;
  logic [23:0]              p2_sum, p2_diff;
  logic [HighW-1:0]         p2h2_d, p2h2_q;
  logic [P2rLowW-1:0]       p2l2_q;
  logic signed [LowInW-1:0] l_s, g_pos, g_neg;

  // stage 3
  cmd_e                     cmd3_q;
  logic [CoeffW-1:0]        a3_q;
  logic                     hint3_q, gsel3_q, mh3_q;
  logic [HighW-1:0]         p2h3_q;
  logic [P2rLowW-1:0]       p2l3_q;

  // stage 4
  cmd_e                     cmd4_q;
  logic [CoeffW-1:0]        a4_q;
  logic                     hint4_q, gsel4_q, mh4_q;
  logic [HighW-1:0]         p2h4_q;
  logic [P2rLowW-1:0]       p2l4_q;
  logic [DecHW-1:0]         dh4;
  logic [CoeffW-1:0]        dm4;

  // stage 5
  cmd_e                     cmd5_q;
  logic                     gsel5_q;
  logic signed [24:0]       diff, r_fold;
  logic                     r_wrap, r_pos;
  logic [DecHW-1:0]         h_use;
  logic [HighW-1:0]         high5_d, high5_q;
  logic [LowW-1:0]          low5_d, low5_q;
  logic                     hb5_d, hb5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma2_select_q <= 1'b0;
    end else if (cfg_we_i) begin
      gamma2_select_q <= cfg_wdata_i;
    end
  end

  assign en5 = !v5_q || out_if.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_if.ready = en1;
  assign dec_en = '{s2: en2, s3: en3, s4: en4};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_if.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: reduce coefficient below q
  assign a1_d = (in_if.coeff >= Q) ? (in_if.coeff - Q) : in_if.coeff;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q  <= cmd_e'(in_if.command);
      a1_q    <= a1_d;
      lin1_q  <= in_if.low_in;
      hnz1_q  <= |in_if.high_in;
      hint1_q <= in_if.hint_in;
      gsel1_q <= gamma2_select_q;
    end
  end

  // stage 2: Power2Round and MakeHint
  always_comb begin
    p2_sum  = {1'b0, a1_q} + 24'd4095;
    p2h2_d  = p2_sum[22:13];
    p2_diff = {1'b0, a1_q} - {1'b0, p2h2_d, 13'b0};
    l_s     = $signed(lin1_q);
    g_pos   = gsel1_q ? $signed({5'b0, Gamma2Large}) : $signed({5'b0, Gamma2Small});
    g_neg   = -g_pos;
    mh2_d   = (l_s > g_pos) || (l_s < g_neg) || ((l_s == g_neg) && hnz1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cmd2_q  <= cmd1_q;
      a2_q    <= a1_q;
      hint2_q <= hint1_q;
      gsel2_q <= gsel1_q;
      p2h2_q  <= p2h2_d;
      p2l2_q  <= p2_diff[P2rLowW-1:0];
      mh2_q   <= mh2_d;
    end
  end

  mrh_decompose u_decompose (
    .clk_i  (clk_i),
    .en_i   (dec_en),
    .a_i    (a1_q),
    .gsel_i (gsel1_q),
    .high_o (dh4),
    .mult_o (dm4)
  );

  always_ff @(posedge clk_i) begin
    if (en3) begin
      cmd3_q  <= cmd2_q;
      a3_q    <= a2_q;
      hint3_q <= hint2_q;
      gsel3_q <= gsel2_q;
      p2h3_q  <= p2h2_q;
      p2l3_q  <= p2l2_q;
      mh3_q   <= mh2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      cmd4_q  <= cmd3_q;
      a4_q    <= a3_q;
      hint4_q <= hint3_q;
      gsel4_q <= gsel3_q;
      p2h4_q  <= p2h3_q;
      p2l4_q  <= p2l3_q;
      mh4_q   <= mh3_q;
    end
  end

  // stage 5: low part with wrap, hint step, result select
  always_comb begin
    diff   = $signed({2'b00, a4_q}) - $signed({2'b00, dm4});
    r_wrap = diff > $signed({2'b00, HalfQ});
    r_fold = r_wrap ? (diff - $signed({2'b00, Q})) : diff;
    r_pos  = (diff > 25'sd0) && !r_wrap;

    h_use = dh4;
    if (hint4_q) begin
      if (gsel4_q) begin
        h_use = r_pos ? ((dh4 + 6'd1) & HighMaskLarge) : ((dh4 + 6'd15) & HighMaskLarge);
      end else if (r_pos) begin
        h_use = (dh4 == HighMaxSmall) ? '0 : dh4 + 6'd1;
      end else begin
        h_use = (dh4 == '0) ? HighMaxSmall : dh4 - 6'd1;
      end
    end

    high5_d = '0;
    low5_d  = '0;
    hb5_d   = 1'b0;
    unique case (cmd4_q)
      CMD_POWER2ROUND: begin
        high5_d = p2h4_q;
        low5_d  = {{(LowW-P2rLowW){p2l4_q[P2rLowW-1]}}, p2l4_q};
      end
      CMD_DECOMPOSE: begin
        high5_d = {{(HighW-DecHW){1'b0}}, dh4};
        low5_d  = r_fold[LowW-1:0];
      end
      CMD_MAKE_HINT: begin
        hb5_d = mh4_q;
      end
      CMD_USE_HINT: begin
        high5_d = {{(HighW-DecHW){1'b0}}, h_use};
      end
      default: begin
        high5_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      cmd5_q  <= cmd4_q;
      gsel5_q <= gsel4_q;
      high5_q <= high5_d;
      low5_q  <= low5_d;
      hb5_q   <= hb5_d;
    end
  end

  assign out_if.valid     = v5_q;
  assign out_if.high_part = high5_q;
  assign out_if.low_part  = low5_q;
  assign out_if.hint_bit  = hb5_q;

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && v5_q && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while pipeline full and stalled");

  a_hint_only_make: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && (cmd5_q != CMD_MAKE_HINT)) |-> !out_if.hint_bit)
    else $error("hint bit set for a command other than make hint");

  a_small_high_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !gsel5_q && (cmd5_q == CMD_DECOMPOSE || cmd5_q == CMD_USE_HINT))
    |-> (out_if.high_part <= 10'd43))
    else $error("high part out of range for small gamma2");

  a_low_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (($signed(out_if.low_part) <= 19'sd261888) &&
                      ($signed(out_if.low_part) >= -19'sd261888)))
    else $error("low part out of range");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for mldsa_rounding_hint_unit. A built-in predictor computes the
// Power2Round, Decompose, MakeHint and UseHint results for each accepted
// coefficient item. A monitor compares every result transfer, field by field,
// against the oldest pending prediction. The run covers directed boundary
// items, then random traffic under both gamma2 settings, with bursty input
// and a patterned output stall.
// ----------------------------------------------------------------------------
module tb;
  import mrh_pkg::*;

  localparam int PipeDepth  = 5;
  localparam int QuietLimit = 2000;

  typedef struct {
    cmd_e        command;
    logic [22:0] coeff;
    logic [23:0] low_in;
    logic [9:0]  high_in;
    logic        hint_in;
  } coeff_item_t;

  typedef struct {
    logic [9:0]  high_part;
    logic [18:0] low_part;
    logic        hint_bit;
  } round_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  mrh_in_if  coeff_ch ();
  mrh_out_if round_ch ();

  mldsa_rounding_hint_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (coeff_ch),
    .out_if      (round_ch)
  );

  round_result_t pending_rounds[$];
  bit            gamma_wide;
  int            mismatch_count;
  int            rounds_checked;
  int            cfg_writes;
  int            cmd_count[4];
  int            quiet_cycles;
  int unsigned   stall_tick;
  int unsigned   stall_mode;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint decompose_high(input longint a, input bit wide,
                                            output longint low);
    longint h;
    longint g;
    longint r;
    g = wide ? longint'(Gamma2Large) : longint'(Gamma2Small);
    h = (a + 127) / 128;
    if (wide) begin
      h = ((h * longint'(MulLarge) + 2097152) / 4194304) & longint'(HighMaskLarge);
    end else begin
      h = (h * longint'(MulSmall) + 8388608) / 16777216;
      if (h > longint'(HighMaxSmall)) h = 0;
    end
    r = a - h * 2 * g;
    if (r > longint'(HalfQ)) r -= longint'(Q);
    low = r;
    return h;
  endfunction

  function automatic round_result_t predict_rounding(input coeff_item_t it,
                                                     input bit wide);
    round_result_t res;
    longint a;
    longint g;
    longint hi;
    longint lo;
    longint r;
    longint lv;
    a  = longint'(it.coeff);
    if (a >= longint'(Q)) a -= longint'(Q);
    g  = wide ? longint'(Gamma2Large) : longint'(Gamma2Small);
    hi = 0;
    lo = 0;
    res.hint_bit = 1'b0;
    case (it.command)
      CMD_POWER2ROUND: begin
        // d = 13
        hi = (a + 4095) / 8192;
        lo = a - hi * 8192;
      end
      CMD_DECOMPOSE: begin
        hi = decompose_high(a, wide, lo);
      end
      CMD_MAKE_HINT: begin
        lv = longint'($signed(it.low_in));
        if (lv > g || lv < -g || (lv == -g && it.high_in != 10'd0)) res.hint_bit = 1'b1;
      end
      default: begin
        hi = decompose_high(a, wide, r);
        if (it.hint_in) begin
          if (wide) begin
            hi = (r > 0) ? ((hi + 1) & longint'(HighMaskLarge))
                         : ((hi + longint'(HighMaskLarge)) & longint'(HighMaskLarge));
          end else if (r > 0) begin
            hi = (hi == longint'(HighMaxSmall)) ? 0 : hi + 1;
          end else begin
            hi = (hi == 0) ? longint'(HighMaxSmall) : hi - 1;
          end
        end
      end
    endcase
    res.high_part = hi[9:0];
    res.low_part  = lo[18:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result monitor and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    round_result_t exp_r;
    if (rst_ni && round_ch.valid && round_ch.ready) begin
      if (pending_rounds.size() == 0) begin
        $error("unexpected transfer: high_part=%0d low_part=%0d hint_bit=%0d",
               round_ch.high_part, $signed(round_ch.low_part), round_ch.hint_bit);
        mismatch_count++;
      end else begin
        exp_r = pending_rounds.pop_front();
        rounds_checked++;
        if (round_ch.high_part !== exp_r.high_part) begin
          $error("high_part mismatch: expected %0d, got %0d",
                 exp_r.high_part, round_ch.high_part);
          mismatch_count++;
        end
        if (round_ch.low_part !== exp_r.low_part) begin
          $error("low_part mismatch: expected %0d, got %0d",
                 $signed(exp_r.low_part), $signed(round_ch.low_part));
          mismatch_count++;
        end
        if (round_ch.hint_bit !== exp_r.hint_bit) begin
          $error("hint_bit mismatch: expected %0d, got %0d",
                 exp_r.hint_bit, round_ch.hint_bit);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((coeff_ch.valid && coeff_ch.ready) || (round_ch.valid && round_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no transfer for %0d cycles", QuietLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Output stall pattern, re-chosen at random from four modes
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       round_ch.ready = 1'b1;
      1:       round_ch.ready = ($urandom_range(0, 1) == 1);
      2:       round_ch.ready = (stall_tick % 4 != 0);
      default: round_ch.ready = (stall_tick % 16 < 5);
    endcase
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic coeff_item_t mk_item(input cmd_e c, input longint coeff,
                                          input longint low, input int high,
                                          input bit hint);
    coeff_item_t it;
    it.command = c;
    it.coeff   = coeff[22:0];
    it.low_in  = low[23:0];
    it.high_in = high[9:0];
    it.hint_in = hint;
    return it;
  endfunction

  function automatic coeff_item_t random_item();
    coeff_item_t it;
    int unsigned sel;
    longint      two_g;
    longint      g;
    longint      v;
    g     = gamma_wide ? longint'(Gamma2Large) : longint'(Gamma2Small);
    two_g = 2 * g;
    it.command = cmd_e'($urandom_range(0, 3));
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      it.coeff = 23'($urandom_range(0, int'(Q) - 1));
    end else if (sel == 5) begin
      it.coeff = 23'($urandom_range(int'(Q), 23'h7FFFFF));
    end else begin
      // near a rounding boundary or near the wrap point
      v = longint'($urandom_range(0, gamma_wide ? 16 : 44)) * two_g;
      if (sel < 8) v = v + longint'($urandom_range(0, 260)) - 130;
      else         v = v + (($urandom_range(0, 1) == 1) ? g : -g)
                         + longint'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      it.coeff = v[22:0];
    end
    if ($urandom_range(0, 1) == 1) begin
      v = (($urandom_range(0, 1) == 1) ? g : -g) + longint'($urandom_range(0, 6)) - 3;
      it.low_in = v[23:0];
    end else begin
      it.low_in = 24'($urandom_range(0, 24'hFFFFFF));
    end
    it.high_in = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
    it.hint_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_coeff(input coeff_item_t it);
    @(negedge clk_i);
    coeff_ch.valid   = 1'b1;
    coeff_ch.command = it.command;
    coeff_ch.coeff   = it.coeff;
    coeff_ch.low_in  = it.low_in;
    coeff_ch.high_in = it.high_in;
    coeff_ch.hint_in = it.hint_in;
    forever begin
      @(posedge clk_i);
      if (coeff_ch.ready) break;
    end
    pending_rounds.push_back(predict_rounding(it, gamma_wide));
    cmd_count[int'(it.command)]++;
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      coeff_ch.valid = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    idle_sender(1);
    while (pending_rounds.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  task automatic write_gamma_select(input bit wide);
    hold_until_drained();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = wide;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    gamma_wide = wide;
    cfg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_power2round();
    send_coeff(mk_item(CMD_POWER2ROUND, 0, 0, 0, 0));
    send_coeff(mk_item(CMD_POWER2ROUND, 4096, 0, 0, 0));
    send_coeff(mk_item(CMD_POWER2ROUND, 4097, 0, 0, 0));
    send_coeff(mk_item(CMD_POWER2ROUND, longint'(Q) - 1, 0, 0, 0));
    send_coeff(mk_item(CMD_POWER2ROUND, 23'h7FFFFF, 0, 0, 0));
  endtask

  task automatic test_decompose();
    send_coeff(mk_item(CMD_DECOMPOSE, longint'(Q) - 1, 0, 0, 0));
    send_coeff(mk_item(CMD_DECOMPOSE, longint'(Gamma2Small), 0, 0, 0));
    send_coeff(mk_item(CMD_DECOMPOSE, longint'(Gamma2Small) + 1, 0, 0, 0));
    send_coeff(mk_item(CMD_DECOMPOSE, longint'(Q), 0, 0, 0));
    write_gamma_select(1'b1);
    send_coeff(mk_item(CMD_DECOMPOSE, longint'(Q) - 1, 0, 0, 0));
    send_coeff(mk_item(CMD_DECOMPOSE, longint'(Gamma2Large), 0, 0, 0));
  endtask

  task automatic test_make_hint();
    longint g;
    g = longint'(Gamma2Large);
    send_coeff(mk_item(CMD_MAKE_HINT, 0, g, 0, 0));
    send_coeff(mk_item(CMD_MAKE_HINT, 0, g + 1, 0, 0));
    send_coeff(mk_item(CMD_MAKE_HINT, 0, -g, 0, 0));
    send_coeff(mk_item(CMD_MAKE_HINT, 0, -g, 1023, 0));
    send_coeff(mk_item(CMD_MAKE_HINT, 0, -g - 1, 0, 0));
    send_coeff(mk_item(CMD_MAKE_HINT, 23'h7FFFFF, 24'h800000, 512, 1));
    send_coeff(mk_item(CMD_MAKE_HINT, 0, 24'h7FFFFF, 0, 0));
  endtask

  task automatic test_use_hint();
    // wide gamma2: wrap down from 0, wrap up from 15, zero low steps down
    send_coeff(mk_item(CMD_USE_HINT, longint'(Q) - 1, 0, 0, 1));
    send_coeff(mk_item(CMD_USE_HINT, 15 * longint'(TwoGamma2Large) + 1, 0, 0, 1));
    send_coeff(mk_item(CMD_USE_HINT, 0, 0, 0, 1));
    send_coeff(mk_item(CMD_USE_HINT, 4 * longint'(TwoGamma2Large) + 5, 0, 0, 0));
    write_gamma_select(1'b0);
    // narrow gamma2: 43 steps up to 0, 0 steps down to 43
    send_coeff(mk_item(CMD_USE_HINT, 43 * longint'(TwoGamma2Small) + 1, 0, 0, 1));
    send_coeff(mk_item(CMD_USE_HINT, 0, 0, 0, 1));
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    int i;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 32);
      for (i = 0; i < burst && sent < n_items; i++) begin
        send_coeff(random_item());
        sent++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3:       idle_sender($urandom_range(10, 20));
        default: idle_sender($urandom_range(1, 6));
      endcase
    end
  endtask

  task automatic test_drain_pause(input int n_items);
    test_random_traffic(n_items / 2);
    hold_until_drained();
    test_random_traffic(n_items - n_items / 2);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 1'b0;
    coeff_ch.valid   = 1'b0;
    coeff_ch.command = CMD_POWER2ROUND;
    coeff_ch.coeff   = '0;
    coeff_ch.low_in  = '0;
    coeff_ch.high_in = '0;
    coeff_ch.hint_in = 1'b0;
    round_ch.ready   = 1'b0;
    gamma_wide       = 1'b0;
    mismatch_count   = 0;
    rounds_checked   = 0;
    cfg_writes       = 0;
    quiet_cycles     = 0;
    stall_tick       = 0;
    stall_mode       = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_power2round();
    test_decompose();
    test_make_hint();
    test_use_hint();

    test_random_traffic(500);
    write_gamma_select(1'b1);
    test_random_traffic(500);
    write_gamma_select(1'b0);
    test_drain_pause(500);
    write_gamma_select(1'b1);
    test_random_traffic(500);

    hold_until_drained();
    repeat (PipeDepth + 5) @(posedge clk_i);

    $display("Checked %0d results: power2round %0d, decompose %0d, make hint %0d, use hint %0d",
             rounds_checked, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
    $display("Both gamma2 settings covered over %0d register writes, %0d mismatches",
             cfg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
